// ----- sv/chts_pkg.sv -----
// shared types, constants and arithmetic helpers for the charge-time touch sensor
// no dependencies; imported by charge_time_touch_sensor
package chts_pkg;

	localparam int ELECTRODES = 4;
	localparam int BASE_SCALE = 16;
	localparam int BASE_SHIFT = $clog2(BASE_SCALE);

	localparam int SPP_W   = 10;
	localparam int PAIRS_W = 4;
	localparam int PHASE_W = PAIRS_W + 1;
	localparam int TIME_W  = 16;
	localparam int BASE_W  = TIME_W + BASE_SHIFT + 1;
	localparam int CFG_W   = SPP_W;
	localparam int IDX_W   = 1;

	localparam logic [TIME_W-1:0] NO_CROSS = '1;

	localparam logic [SPP_W-1:0]   SPP_RESET   = SPP_W'(100);
	localparam logic [PAIRS_W-1:0] PAIRS_RESET = PAIRS_W'(5);

	typedef enum logic [IDX_W-1:0] {
		REG_SAMPLES_PER_PHASE = 1'b0,
		REG_PHASE_PAIRS       = 1'b1
	} reg_index_t;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [BASE_W-1:0] base_t;

	typedef struct packed {
		time_t delta;
		base_t baseline;
	} track_t;

	// sticky, saturating add of one phase time into a sum
	function automatic time_t add_time(input time_t sum, input time_t t);
		logic [TIME_W:0] s;
		begin
			s = {1'b0, sum} + {1'b0, t};
			if (sum == NO_CROSS || t == NO_CROSS || s >= {1'b0, NO_CROSS}) begin
				add_time = NO_CROSS;
			end else begin
				add_time = s[TIME_W-1:0];
			end
		end
	endfunction

	// baseline update and delta for one electrode at end of measurement
	function automatic track_t track(input time_t sum, input base_t base, input logic loaded);
		base_t           lower;
		logic [BASE_W:0] b;
		logic [BASE_W:0] diff;
		logic [BASE_W+2:0] diff3;
		logic [BASE_W:0] dec;
		base_t           nb;
		logic [TIME_W:0] scaled;
		track_t          r;
		begin
			lower = {{(BASE_W-TIME_W-BASE_SHIFT){1'b0}}, sum, {BASE_SHIFT{1'b0}}};
			b     = {1'b0, base} + {{BASE_W{1'b0}}, 1'b1};
			diff  = b - {1'b0, lower};
			diff3 = {2'b00, diff} + {1'b0, diff, 1'b0};
			dec   = {1'b0, lower} + diff3[BASE_W+2:2];
			if (!loaded) begin
				nb = lower;
			end else if (b > {1'b0, lower}) begin
				nb = dec[BASE_W-1:0];
			end else begin
				nb = b[BASE_W-1:0];
			end
			scaled = nb[BASE_W-1:BASE_SHIFT];
			r.baseline = nb;
			if ({1'b0, sum} > scaled) begin
				r.delta = TIME_W'({1'b0, sum} - scaled);
			end else begin
				r.delta = '0;
			end
			track = r;
		end
	endfunction

endpackage

// ----- sv/charge_time_touch_sensor.sv -----
// charge-time touch sensor: phase sequencing, crossing capture, baseline tracking
// depends on chts_pkg
//
// usage
//  - input channel lines/lines_valid/lines_stall: one sample of the four electrode
//    lines per transfer; bit j is electrode j
//  - output channel delta_0..delta_3/delta_valid/delta_stall: one transfer at the end
//    of each measurement (2*phase_pairs phases of samples_per_phase samples)
//  - config port wr_en/wr_index/wr_data: index 0 samples_per_phase, 1 phase_pairs;
//    write only while idle
//  - throughput: one sample per clock while lines_stall is low; the sample counter,
//    crossing capture and sum add complete in the accept cycle
//  - the transfer of a measurement's last sample loads the final sums; they then pass
//    through the baseline update into the output register, which raises delta_valid
//  - a stalled result holds; the final-sum register still takes the next measurement
//    end, and lines_stall rises while that register is full and cannot move on
//  - reset clears counters, crossing times (to not crossed), sums, baselines and
//    the baseline-loaded flag, and restores register defaults 100 and 5
module charge_time_touch_sensor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [chts_pkg::IDX_W-1:0] wr_index,
	input  logic [chts_pkg::CFG_W-1:0] wr_data,
	input  logic [3:0]                lines,
	input  logic                      lines_valid,
	output logic                      lines_stall,
	output logic [15:0]               delta_0,
	output logic [15:0]               delta_1,
	output logic [15:0]               delta_2,
	output logic [15:0]               delta_3,
	output logic                      delta_valid,
	input  logic                      delta_stall
);
	import chts_pkg::*;

	// configuration
	logic [SPP_W-1:0]   spp_q;
	logic [PAIRS_W-1:0] pairs_q;

	// sequencing and per-phase state
	logic [SPP_W-1:0]   sample_q;
	logic [PHASE_W-1:0] phase_q;
	time_t              cross_q [ELECTRODES];
	time_t              sum_q   [ELECTRODES];

	// final sums waiting for baseline update
	time_t              sum_s1  [ELECTRODES];
	logic               valid_s1;

	// baselines and output
	base_t              base_q  [ELECTRODES];
	logic               loaded_q;
	time_t              delta_q [ELECTRODES];
	logic               valid_q;

	logic               accept;
	logic               adv_s1;
	logic [SPP_W-1:0]   spp_eff;
	logic [PHASE_W-1:0] phases;
	logic               phase_end;
	logic               meas_end;
	logic               level;
	time_t              cross_new [ELECTRODES];
	time_t              sum_new   [ELECTRODES];
	track_t             trk       [ELECTRODES];

	// register at zero acts as one
	assign spp_eff = (spp_q == '0) ? SPP_W'(1) : spp_q;
	assign phases  = {((pairs_q == '0) ? PAIRS_W'(1) : pairs_q), 1'b0};

	assign phase_end = ({1'b0, sample_q} + {{SPP_W{1'b0}}, 1'b1}) >= {1'b0, spp_eff};
	assign meas_end  = phase_end
		&& (({1'b0, phase_q} + {{PHASE_W{1'b0}}, 1'b1}) >= {1'b0, phases});

	// even phases drive high, odd phases low
	assign level = ~phase_q[0];

	// final-sum stage moves on whenever the output register is free or draining
	assign adv_s1      = valid_s1 && (!valid_q || !delta_stall);
	assign lines_stall = valid_s1 && !adv_s1;
	assign accept      = lines_valid && !lines_stall;

	always_comb begin
		for (int j = 0; j < ELECTRODES; j++) begin
			if (cross_q[j] == NO_CROSS && lines[j] == level) begin
				cross_new[j] = {{(TIME_W-SPP_W){1'b0}}, sample_q};
			end else begin
				cross_new[j] = cross_q[j];
			end
			sum_new[j] = add_time(sum_q[j], cross_new[j]);
			trk[j]     = track(sum_s1[j], base_q[j], loaded_q);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q   <= SPP_RESET;
			pairs_q <= PAIRS_RESET;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_SAMPLES_PER_PHASE: spp_q   <= wr_data;
				REG_PHASE_PAIRS:       pairs_q <= wr_data[PAIRS_W-1:0];
				default:               ;
			endcase
		end
	end

	// sample capture, phase and measurement sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
			phase_q  <= '0;
			valid_s1 <= 1'b0;
			for (int j = 0; j < ELECTRODES; j++) begin
				cross_q[j] <= NO_CROSS;
				sum_q[j]   <= '0;
			end
		end else begin
			if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (accept) begin
				if (!phase_end) begin
					sample_q <= sample_q + SPP_W'(1);
					for (int j = 0; j < ELECTRODES; j++) begin
						cross_q[j] <= cross_new[j];
					end
				end else begin
					sample_q <= '0;
					for (int j = 0; j < ELECTRODES; j++) begin
						cross_q[j] <= NO_CROSS;
						sum_q[j]   <= meas_end ? '0 : sum_new[j];
					end
					if (meas_end) begin
						phase_q  <= '0;
						valid_s1 <= 1'b1;
					end else begin
						phase_q <= phase_q + PHASE_W'(1);
					end
				end
			end
		end
	end

	// final sums, no reset needed
	always_ff @(posedge clk) begin
		if (accept && meas_end) begin
			for (int j = 0; j < ELECTRODES; j++) begin
				sum_s1[j] <= sum_new[j];
			end
		end
	end

	// baseline update on the way into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			valid_q  <= 1'b0;
			for (int j = 0; j < ELECTRODES; j++) begin
				base_q[j] <= '0;
			end
		end else begin
			if (adv_s1) begin
				loaded_q <= 1'b1;
				valid_q  <= 1'b1;
				for (int j = 0; j < ELECTRODES; j++) begin
					base_q[j] <= trk[j].baseline;
				end
			end else if (!delta_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int j = 0; j < ELECTRODES; j++) begin
				delta_q[j] <= trk[j].delta;
			end
		end
	end

	assign delta_valid = valid_q;
	assign delta_0     = delta_q[0];
	assign delta_1     = delta_q[1];
	assign delta_2     = delta_q[2];
	assign delta_3     = delta_q[3];

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for charge_time_touch_sensor: drives electrode samples and
// register writes, predicts each measurement's deltas and compares every output transfer
// depends on chts_pkg and charge_time_touch_sensor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT  = 50000;	// cycle budget, several times the slowest clean run
	localparam int SETTLE = 6;	// cycles past the last result before touching registers
	localparam int HOLD   = 300;	// length of the long receiver hold-off
	localparam logic [15:0] NOT_CROSSED = 16'hffff;

	// one result: deltas of electrodes 3..0
	typedef logic [3:0][15:0] delta_set_t;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       wr_en       = 1'b0;
	logic [chts_pkg::IDX_W-1:0] wr_index    = '0;
	logic [chts_pkg::CFG_W-1:0] wr_data     = '0;
	logic [3:0]                 lines       = '0;
	logic                       lines_valid = 1'b0;
	logic                       lines_stall;
	logic [15:0]                delta_0;
	logic [15:0]                delta_1;
	logic [15:0]                delta_2;
	logic [15:0]                delta_3;
	logic                       delta_valid;
	logic                       delta_stall = 1'b0;

	charge_time_touch_sensor dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.lines       (lines),
		.lines_valid (lines_valid),
		.lines_stall (lines_stall),
		.delta_0     (delta_0),
		.delta_1     (delta_1),
		.delta_2     (delta_2),
		.delta_3     (delta_3),
		.delta_valid (delta_valid),
		.delta_stall (delta_stall)
	);

	always #6 clk = ~clk;

	// samples waiting to be offered, and deltas the sensor still owes us
	logic [3:0]  sample_queue [$];
	delta_set_t  deltas_due [$];

	int samples_queued = 0;
	int errors         = 0;
	int cycle_count    = 0;

	// no idling on either side while set
	logic steady    = 1'b0;
	// long hold-off request, taken once by the receiver
	logic hold_req  = 1'b0;
	logic hold_done = 1'b0;
	int   hold_cnt  = 0;

	// predictor copy of the registers and of the measurement state
	logic [9:0]  cfg_spp   = chts_pkg::SPP_RESET;
	logic [3:0]  cfg_pairs = chts_pkg::PAIRS_RESET;
	logic [9:0]  smp_idx   = '0;
	logic [4:0]  phase_idx = '0;
	logic [15:0] cross_t [4] = '{NOT_CROSSED, NOT_CROSSED, NOT_CROSSED, NOT_CROSSED};
	logic [15:0] sum_t [4]   = '{16'd0, 16'd0, 16'd0, 16'd0};
	logic [20:0] track_base [4] = '{21'd0, 21'd0, 21'd0, 21'd0};
	logic        base_loaded = 1'b0;

	// advance the measurement by one accepted sample; queue the deltas at its end
	task automatic measure_sample(input logic [3:0] smp);
		int unsigned spp;
		int unsigned phases;
		int unsigned lower;
		int unsigned b;
		int unsigned scaled;
		logic        lvl;
		delta_set_t  d;
		// zero in a register behaves like one
		spp    = (cfg_spp == 0) ? 1 : cfg_spp;
		phases = 2 * ((cfg_pairs == 0) ? 1 : cfg_pairs);
		// drive high in even phases, low in odd ones
		lvl    = ~phase_idx[0];
		for (int j = 0; j < 4; j++) begin
			if (cross_t[j] == NOT_CROSSED && smp[j] == lvl) begin
				cross_t[j] = 16'(smp_idx);
			end
		end
		if (32'(smp_idx) + 1 < spp) begin
			smp_idx = smp_idx + 10'd1;
			return;
		end
		// end of phase: sticky, saturating sum of crossing times
		for (int j = 0; j < 4; j++) begin
			if (sum_t[j] == NOT_CROSSED || cross_t[j] == NOT_CROSSED ||
					32'(sum_t[j]) + 32'(cross_t[j]) >= 32'(NOT_CROSSED)) begin
				sum_t[j] = NOT_CROSSED;
			end else begin
				sum_t[j] = sum_t[j] + cross_t[j];
			end
			cross_t[j] = NOT_CROSSED;
		end
		smp_idx = '0;
		if (32'(phase_idx) + 1 < phases) begin
			phase_idx = phase_idx + 5'd1;
			return;
		end
		// end of measurement: baseline tracking at 16x scale
		phase_idx = '0;
		for (int j = 0; j < 4; j++) begin
			lower = 32'(sum_t[j]) * chts_pkg::BASE_SCALE;
			if (!base_loaded) begin
				b = lower;
			end else begin
				b = 32'(track_base[j]) + 1;
				if (b > lower) begin
					b = lower + (b - lower) * 3 / 4;
				end
			end
			track_base[j] = b[20:0];
			scaled = b / chts_pkg::BASE_SCALE;
			d[j] = (32'(sum_t[j]) > scaled) ? 16'(32'(sum_t[j]) - scaled) : 16'd0;
			sum_t[j] = '0;
		end
		base_loaded = 1'b1;
		deltas_due.push_back(d);
	endtask

	// queue n samples shaped like real charge curves, aligned to the current phase
	task automatic queue_samples(input int n, input int noise_pct);
		int         spp;
		int         phases;
		int         gen_smp;
		int         gen_phase;
		int         cross_at [4];
		logic       lvl;
		logic [3:0] smp;
		spp       = (cfg_spp == 0) ? 1 : int'(cfg_spp);
		phases    = 2 * ((cfg_pairs == 0) ? 1 : int'(cfg_pairs));
		gen_smp   = int'(smp_idx);
		gen_phase = int'(phase_idx);
		for (int k = 0; k < n; k++) begin
			lvl = ~gen_phase[0];
			// new crossing point per electrode at each phase start; some never cross
			if (k == 0 || gen_smp == 0) begin
				for (int j = 0; j < 4; j++) begin
					cross_at[j] = ($urandom_range(99) < 15) ? spp : $urandom_range(spp - 1);
				end
			end
			for (int j = 0; j < 4; j++) begin
				if (gen_smp >= cross_at[j]) begin
					smp[j] = ($urandom_range(99) < 25) ? 1'($urandom_range(1)) : lvl;
				end else begin
					smp[j] = ~lvl;
				end
			end
			if ($urandom_range(99) < noise_pct) begin
				smp = 4'($urandom_range(15));
			end
			sample_queue.push_back(smp);
			samples_queued++;
			if (gen_smp + 1 < spp) begin
				gen_smp++;
			end else begin
				gen_smp = 0;
				gen_phase = (gen_phase + 1 < phases) ? gen_phase + 1 : 0;
			end
		end
	endtask

	// wait until every sample is in and every delta is out, then let the pipe drain
	task automatic settle();
		do begin
			@(posedge clk);
		end while (sample_queue.size() != 0 || lines_valid || deltas_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// one register write, mirrored into the predictor
	task automatic write_reg(input chts_pkg::reg_index_t idx, input logic [9:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == chts_pkg::REG_SAMPLES_PER_PHASE) begin
			cfg_spp = val;
		end else begin
			cfg_pairs = val[3:0];
		end
	endtask

	// sample driver: predicts on every input transfer, then offers the next sample
	always @(posedge clk) begin : driver
		if (lines_valid && !lines_stall) begin
			measure_sample(lines);
		end
		// a stalled sample holds; otherwise load the next one or idle
		if (!lines_valid || !lines_stall) begin
			if (sample_queue.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
				lines       <= sample_queue.pop_front();
				lines_valid <= 1'b1;
			end else begin
				lines       <= 4'($urandom_range(15));
				lines_valid <= 1'b0;
			end
		end
	end

	// result monitor: checks each output transfer and drives the stall
	always @(posedge clk) begin : monitor
		delta_set_t got;
		delta_set_t want;
		if (delta_valid && !delta_stall) begin
			got = {delta_3, delta_2, delta_1, delta_0};
			if (deltas_due.size() == 0) begin
				$error("delta transfer with nothing expected: %h", got);
				errors++;
			end else begin
				want = deltas_due.pop_front();
				for (int j = 0; j < 4; j++) begin
					if (got[j] !== want[j]) begin
						$error("delta_%0d: expected %0d, actual %0d", j, want[j], got[j]);
						errors++;
					end
				end
			end
		end
		// long hold-off counted here, otherwise random stalls
		if (hold_cnt != 0) begin
			delta_stall <= 1'b1;
			hold_cnt    <= hold_cnt - 1;
		end else if (hold_req && !hold_done) begin
			delta_stall <= 1'b1;
			hold_cnt    <= HOLD;
			hold_done   <= 1'b1;
		end else begin
			delta_stall <= !steady && ($urandom_range(99) < 20);
		end
	end

	// watchdog
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("charge_time_touch_sensor regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		logic [3:0] corner_a [8];
		logic [3:0] corner_b [18];
		int         rounds;
		int         spp_pick;
		int         pairs_pick;
		int         eff_spp;
		int         eff_pairs;
		int         len;
		// spp and pairs at one: both cross at zero, never cross (sticky 65535), split
		corner_a = '{4'hf, 4'h0, 4'h0, 4'hf, 4'hf, 4'h0, 4'h5, 4'ha};
		// three samples per phase: late crossings, early crossings, partial crossings
		corner_b = '{4'h0, 4'h0, 4'hf, 4'hf, 4'hf, 4'h0,
			4'hf, 4'h0, 4'h0, 4'h0, 4'hf, 4'hf,
			4'h3, 4'hc, 4'h0, 4'ha, 4'h5, 4'hf};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register defaults after reset: one and a half phases of 100 samples,
		// then short phases finish the default ten-phase measurement
		queue_samples(150, 3);
		settle();
		write_reg(chts_pkg::REG_SAMPLES_PER_PHASE, 10'd2);
		queue_samples(17, 3);
		settle();

		// registers at zero act as one
		write_reg(chts_pkg::REG_SAMPLES_PER_PHASE, 10'd0);
		write_reg(chts_pkg::REG_PHASE_PAIRS, 10'd0);
		foreach (corner_a[i]) begin
			sample_queue.push_back(corner_a[i]);
			samples_queued++;
		end
		settle();

		write_reg(chts_pkg::REG_SAMPLES_PER_PHASE, 10'd3);
		write_reg(chts_pkg::REG_PHASE_PAIRS, 10'd1);
		foreach (corner_b[i]) begin
			sample_queue.push_back(corner_b[i]);
			samples_queued++;
		end
		settle();

		// phase shortened under a running sample counter
		write_reg(chts_pkg::REG_SAMPLES_PER_PHASE, 10'd4);
		write_reg(chts_pkg::REG_PHASE_PAIRS, 10'd2);
		queue_samples(7, 0);
		settle();
		write_reg(chts_pkg::REG_SAMPLES_PER_PHASE, 10'd2);
		queue_samples(40, 3);
		settle();

		// measurement shortened under a running phase counter
		write_reg(chts_pkg::REG_PHASE_PAIRS, 10'd3);
		queue_samples(9, 0);
		settle();
		write_reg(chts_pkg::REG_PHASE_PAIRS, 10'd1);
		queue_samples(20, 3);
		settle();

		// largest sample count: a long phase, then cut short by a smaller setting
		write_reg(chts_pkg::REG_SAMPLES_PER_PHASE, 10'd1023);
		write_reg(chts_pkg::REG_PHASE_PAIRS, 10'd1);
		queue_samples(300, 2);
		settle();
		write_reg(chts_pkg::REG_SAMPLES_PER_PHASE, 10'd1);
		queue_samples(2, 2);
		settle();
		write_reg(chts_pkg::REG_PHASE_PAIRS, 10'd15);
		queue_samples(30, 3);
		settle();

		// receiver holds off while short measurements keep coming: input must stall
		write_reg(chts_pkg::REG_PHASE_PAIRS, 10'd1);
		hold_req = 1'b1;
		queue_samples(60, 5);
		settle();

		// random rounds: mostly short measurements, now and then a longer phase
		rounds = 0;
		while (samples_queued < 850) begin
			rounds++;
			// one stretch of rounds with no idling on either side
			steady = (rounds >= 2 && rounds <= 3);
			if ($urandom_range(7) == 0) begin
				spp_pick   = $urandom_range(30, 10);
				pairs_pick = 1;
			end else begin
				spp_pick   = $urandom_range(5, 1);
				pairs_pick = $urandom_range(3, 1);
			end
			if ($urandom_range(11) == 0) begin
				spp_pick = 0;
			end
			if ($urandom_range(11) == 0) begin
				pairs_pick = 0;
			end
			write_reg(chts_pkg::REG_SAMPLES_PER_PHASE, 10'(spp_pick));
			if ($urandom_range(3) != 0) begin
				write_reg(chts_pkg::REG_PHASE_PAIRS, 10'(pairs_pick));
			end
			eff_spp   = (cfg_spp == 0) ? 1 : int'(cfg_spp);
			eff_pairs = (cfg_pairs == 0) ? 1 : int'(cfg_pairs);
			if (eff_spp >= 10) begin
				len = 2 * eff_pairs * eff_spp + $urandom_range(eff_spp);
			end else begin
				len = $urandom_range(4, 1) * 2 * eff_pairs * eff_spp
					+ $urandom_range(eff_spp);
			end
			queue_samples(len, ($urandom_range(9) == 0) ? 50 : 3);
			settle();
		end
		steady = 1'b0;

		// everything in and out, pipe drained
		settle();
		if (errors == 0 && deltas_due.size() == 0) begin
			$display("charge_time_touch_sensor regression: pass");
		end else begin
			$display("charge_time_touch_sensor regression: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
sv/chts_pkg.sv
sv/charge_time_touch_sensor.sv
tb/sv/testbench.sv
